[rtl/mie_pkg.sv]
// ----------------------------------------------------------------------------
// mie_pkg
// Microcode words, step addresses and control store for the modular inverse
// sequencer.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int PC_W      = 3;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t P_IDLE  = 3'd0;
  localparam pc_t P_CHKM  = 3'd1;
  localparam pc_t P_LOOP  = 3'd2;
  localparam pc_t P_ALIGN = 3'd3;
  localparam pc_t P_DIV   = 3'd4;
  localparam pc_t P_ADD   = 3'd5;
  localparam pc_t P_SWAP  = 3'd6;
  localparam pc_t P_DONE  = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT_DIV,
    OP_SHL,
    OP_DIVSTEP,
    OP_ACCADD,
    OP_SWAP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_M_SMALL,
    C_RB_ZERO,
    C_CAN_SHIFT,
    C_K_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  // Jump to target when cond holds, else fall through to the next step.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: C_NEVER, target: P_IDLE};
    case (pc)
      P_IDLE:  cw = '{op: OP_LOAD,     cond: C_NO_START,  target: P_IDLE};
      P_CHKM:  cw = '{op: OP_NOP,      cond: C_M_SMALL,   target: P_DONE};
      P_LOOP:  cw = '{op: OP_INIT_DIV, cond: C_RB_ZERO,   target: P_DONE};
      P_ALIGN: cw = '{op: OP_SHL,      cond: C_CAN_SHIFT, target: P_ALIGN};
      P_DIV:   cw = '{op: OP_DIVSTEP,  cond: C_NEVER,     target: P_IDLE};
      P_ADD:   cw = '{op: OP_ACCADD,   cond: C_K_NZ,      target: P_DIV};
      P_SWAP:  cw = '{op: OP_SWAP,     cond: C_ALWAYS,    target: P_LOOP};
      P_DONE:  cw = '{op: OP_EMIT,     cond: C_OUT_BUSY,  target: P_DONE};
      default: cw = '{op: OP_NOP,      cond: C_ALWAYS,    target: P_IDLE};
    endcase
    return cw;
  endfunction

endpackage

[rtl/modular_inverse_ext_euclid.sv]
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse by the extended Euclidean algorithm, run by a microcoded
// sequencer over a shift-subtract divider and a modular coefficient unit.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_stall, in_value, in_modulus | in
//  result  | out_valid, out_stall, out_inverse,       | out
//          | out_no_inverse                           |
//
//  One transaction at a time. Each division step runs initialise, one
//  alignment shift per doubling of the divisor, then a subtract and a
//  coefficient add per quotient bit, then the swap; around the loop run
//  load, modulus check, final remainder test and emit (the loop is skipped
//  when the modulus is below 2).
//  The divider loop (align, subtract, coefficient add) takes most of the time.
//  Reset is synchronous; the sequencer returns to its idle step.
//  A stalled result sits in the output register while the next request
//  is taken.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
  parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_value,
  input  logic [WIDTH-1:0] in_modulus,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_inverse,
  output logic             out_no_inverse
);

  localparam int KW = $clog2(WIDTH);

  mie_pkg::pc_t        pc_r, pc_nxt;
  mie_pkg::ctrl_word_t cw;

  logic [WIDTH-1:0] ra_r, rb_r, sa_r, sb_r, m_r, t_r, acc_r;
  logic [KW-1:0]    k_r;
  logic             bit_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_inverse_r;
  logic             out_no_inverse_r;

  logic             in_fire, out_free, cond_ok;
  logic             m_small, can_shift, ra_ge_t, k_nz, no_inv;
  logic [WIDTH:0]   t_dbl, acc_dbl_s, acc_add_s;
  logic [WIDTH-1:0] acc_dbl, acc_add, s_new;

  assign cw       = mie_pkg::ucode(pc_r);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign m_small   = m_r < WIDTH'(2);
  assign t_dbl     = {t_r, 1'b0};
  assign can_shift = t_dbl <= {1'b0, ra_r};
  assign ra_ge_t   = ra_r >= t_r;
  assign k_nz      = k_r != '0;

  assign acc_dbl_s = {acc_r, 1'b0};
  assign acc_dbl   = (acc_dbl_s >= {1'b0, m_r}) ? WIDTH'(acc_dbl_s - {1'b0, m_r})
                                                : acc_dbl_s[WIDTH-1:0];
  assign acc_add_s = {1'b0, acc_r} + {1'b0, sb_r};
  assign acc_add   = (acc_add_s >= {1'b0, m_r}) ? WIDTH'(acc_add_s - {1'b0, m_r})
                                                : acc_add_s[WIDTH-1:0];
  assign s_new     = (sa_r >= acc_r) ? (sa_r - acc_r) : (sa_r - acc_r + m_r);
  assign no_inv    = m_small || (ra_r != WIDTH'(1));

  always_comb begin
    case (cw.cond)
      mie_pkg::C_NEVER:     cond_ok = 1'b0;
      mie_pkg::C_ALWAYS:    cond_ok = 1'b1;
      mie_pkg::C_NO_START:  cond_ok = !in_valid;
      mie_pkg::C_M_SMALL:   cond_ok = m_small;
      mie_pkg::C_RB_ZERO:   cond_ok = rb_r == '0;
      mie_pkg::C_CAN_SHIFT: cond_ok = can_shift;
      mie_pkg::C_K_NZ:      cond_ok = k_nz;
      mie_pkg::C_OUT_BUSY:  cond_ok = !out_free;
      default:              cond_ok = 1'b0;
    endcase
    pc_nxt = cond_ok ? cw.target : pc_r + 1'b1;
  end

  always_comb begin
    in_stall       = pc_r != mie_pkg::P_IDLE;
    out_valid      = out_valid_r;
    out_inverse    = out_inverse_r;
    out_no_inverse = out_no_inverse_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mie_pkg::P_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.op == mie_pkg::OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      mie_pkg::OP_LOAD: begin
        if (in_fire) begin
          m_r  <= in_modulus;
          ra_r <= in_modulus;
          rb_r <= in_value;
          sa_r <= '0;
          sb_r <= WIDTH'(1);
        end
      end
      mie_pkg::OP_INIT_DIV: begin
        t_r   <= rb_r;
        k_r   <= '0;
        acc_r <= '0;
      end
      mie_pkg::OP_SHL: begin
        if (can_shift) begin
          t_r <= t_dbl[WIDTH-1:0];
          k_r <= k_r + 1'b1;
        end
      end
      mie_pkg::OP_DIVSTEP: begin
        acc_r <= acc_dbl;
        bit_r <= ra_ge_t;
        if (ra_ge_t) begin
          ra_r <= ra_r - t_r;
        end
      end
      mie_pkg::OP_ACCADD: begin
        if (bit_r) begin
          acc_r <= acc_add;
        end
        if (k_nz) begin
          k_r <= k_r - 1'b1;
          t_r <= t_r >> 1;
        end
      end
      mie_pkg::OP_SWAP: begin
        ra_r <= rb_r;
        rb_r <= ra_r;
        sa_r <= sb_r;
        sb_r <= s_new;
      end
      mie_pkg::OP_EMIT: begin
        if (out_free) begin
          out_no_inverse_r <= no_inv;
          out_inverse_r    <= no_inv ? '0 : sa_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_no_inverse_r |-> out_inverse_r == '0)
    else $error("no-inverse result carries a non-zero inverse");

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == mie_pkg::P_DONE)
    else $error("result raised outside the emit step");

  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == mie_pkg::P_ADD |-> acc_r < m_r)
    else $error("coefficient accumulator out of range");

  a_coef_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == mie_pkg::P_LOOP && !m_small |-> sa_r < m_r && sb_r < m_r)
    else $error("Bezout coefficients out of range");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == mie_pkg::P_SWAP |-> ra_r < rb_r)
    else $error("remainder not below divisor after division");

endmodule

[tb/modular_inverse_ext_euclid_test.sv]
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_test
// Self-checking bench for the modular inverse unit. Each request is predicted
// by a signed extended Euclid run, queued in a scoreboard and compared field by
// field with the returned result. Directed corner requests come first, then
// mixed random traffic with bursty input pacing and patterned result stalls.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W              = mie_pkg::WIDTH_DEF;
  localparam int N_RANDOM       = 1330;
  localparam int DRAIN_EVERY    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int SHOW_MAX       = 10;

  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic         no_inverse;
  } inverse_entry_t;

  class inverse_scoreboard;
    inverse_entry_t awaited[$];
    int unsigned    n_requests;
    int unsigned    n_no_inverse;
    int unsigned    n_checked;
    int unsigned    n_failures;

    function void flag_failure(string what);
      n_failures++;
      if (n_failures <= SHOW_MAX) $display("%s", what);
    endfunction

    function void modular_inverse(input logic [W-1:0] value, input logic [W-1:0] modulus,
                                  output logic [W-1:0] inverse, output logic no_inverse);
      longint r_old, r_new, c_old, c_new, quot, tmp, m64;
      inverse    = '0;
      no_inverse = 1'b1;
      if (modulus < 2) return;
      m64   = modulus;
      r_old = m64;
      r_new = value % modulus;
      c_old = 0;
      c_new = 1;
      while (r_new != 0) begin
        quot  = r_old / r_new;
        tmp   = r_old - quot * r_new;
        r_old = r_new;
        r_new = tmp;
        tmp   = c_old - quot * c_new;
        c_old = c_new;
        c_new = tmp;
      end
      if (r_old == 1) begin
        if (c_old < 0) c_old = c_old + m64;
        inverse    = c_old[W-1:0];
        no_inverse = 1'b0;
      end
    endfunction

    function void note_request(logic [W-1:0] value, logic [W-1:0] modulus);
      inverse_entry_t e;
      e.value   = value;
      e.modulus = modulus;
      modular_inverse(value, modulus, e.inverse, e.no_inverse);
      awaited.push_back(e);
      n_requests++;
      if (e.no_inverse) n_no_inverse++;
    endfunction

    function void check_result(logic [W-1:0] inverse, logic no_inverse);
      inverse_entry_t e;
      if (awaited.size() == 0) begin
        flag_failure($sformatf("unexpected result: inverse %0d no_inverse %b",
                               inverse, no_inverse));
        return;
      end
      e = awaited.pop_front();
      n_checked++;
      if (inverse !== e.inverse || no_inverse !== e.no_inverse)
        flag_failure($sformatf({"mismatch for value %0d modulus %0d: expected inverse %0d ",
                                "no_inverse %b, got inverse %0d no_inverse %b"},
                               e.value, e.modulus, e.inverse, e.no_inverse,
                               inverse, no_inverse));
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_valid   = 1'b0;
  logic [W-1:0] in_value   = '0;
  logic [W-1:0] in_modulus = '0;
  logic         out_stall  = 1'b0;
  logic         in_stall;
  logic         out_valid;
  logic [W-1:0] out_inverse;
  logic         out_no_inverse;

  inverse_scoreboard sb = new;

  int unsigned burst_left  = 0;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode  = 0;
  int unsigned idle_cycles = 0;

  modular_inverse_ext_euclid #(.WIDTH(W)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_modulus    (in_modulus),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inverse   (out_inverse),
    .out_no_inverse(out_no_inverse)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_inverse, out_no_inverse);
    if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
    stall_cycle++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_cycle % 16) < 5);
    endcase
  end

  task automatic send_request(input logic [W-1:0] value, input logic [W-1:0] modulus);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
      gap        = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= value;
    in_modulus <= modulus;
    do @(posedge clk); while (in_stall);
    sb.note_request(value, modulus);
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic pick_request(output logic [W-1:0] value, output logic [W-1:0] modulus);
    longint      fa, fb, ft;
    int unsigned g;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        value   = $urandom;
        modulus = $urandom;
      end
      3: begin
        value   = $urandom;
        modulus = $urandom_range(0, 16);
      end
      4: begin
        value   = $urandom >> $urandom_range(0, 31);
        modulus = $urandom | 32'd1;
      end
      5: begin
        value   = $urandom >> $urandom_range(0, 31);
        modulus = $urandom >> $urandom_range(0, 31);
      end
      6: begin
        g       = $urandom_range(2, 64);
        value   = g * $urandom_range(0, 1 << 24);
        modulus = g * $urandom_range(1, 1 << 24);
      end
      7: begin
        modulus = $urandom_range(2, 65535);
        value   = modulus * $urandom_range(0, 65535);
      end
      8: begin
        fa = 1;
        fb = 1;
        repeat ($urandom_range(1, 45)) begin
          ft = fa + fb;
          fa = fb;
          fb = ft;
        end
        if ($urandom_range(0, 1)) begin
          value   = fa[W-1:0];
          modulus = fb[W-1:0];
        end else begin
          value   = fb[W-1:0];
          modulus = fa[W-1:0];
        end
      end
      default: begin
        value   = $urandom;
        modulus = 32'd1 << $urandom_range(1, 31);
      end
    endcase
  endtask

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("modular_inverse_ext_euclid regression: fail");
    $finish;
  end

  initial begin
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(32'd0,          32'd0);
    send_request(32'hFFFFFFFF,   32'd0);
    send_request(32'd5,          32'd1);
    send_request(32'hFFFFFFFF,   32'd1);
    send_request(32'd0,          32'd7);
    send_request(32'd1,          32'd2);
    send_request(32'd2,          32'd2);
    send_request(32'd3,          32'd2);
    send_request(32'd1,          32'hFFFFFFFF);
    send_request(32'hFFFFFFFF,   32'hFFFFFFFF);
    send_request(32'hFFFFFFFF,   32'hFFFFFFFE);
    send_request(32'hFFFFFFFE,   32'hFFFFFFFF);
    send_request(32'd3,          32'hFFFFFFFF);
    send_request(32'h80000000,   32'hFFFFFFFF);
    send_request(32'd12,         32'd4);
    send_request(32'd100,        32'd7);
    send_request(32'd6,          32'd9);
    send_request(32'hAAAAAAAA,   32'h55555555);
    send_request(32'hFFFFFFFF,   32'h80000000);
    send_request(32'd1836311903, 32'd2971215073);
    send_request(32'd2971215073, 32'd1836311903);
    send_request(32'd2,          32'd4294967291);
    send_request(32'd12345,      32'd65537);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      pick_request(value, modulus);
      send_request(value, modulus);
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.flag_failure($sformatf("%0d requests never answered", sb.awaited.size()));

    $display("covered %0d requests (%0d without an inverse), %0d results checked, %0d failures",
             sb.n_requests, sb.n_no_inverse, sb.n_checked, sb.n_failures);
    if (sb.n_failures == 0) begin
      $display("modular_inverse_ext_euclid regression: pass");
    end else begin
      $display("modular_inverse_ext_euclid regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mie_pkg.sv
rtl/modular_inverse_ext_euclid.sv
tb/modular_inverse_ext_euclid_test.sv
